FILE: rtl/assert_macros.svh
// assertion macros shared by the block's rtl files
// no dependencies; included by the files that carry assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define ACT_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// condition holds at every clock edge
`define ACT_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("assertion failed");

`endif

FILE: rtl/act_pkg.sv
// types, constants and helper functions for the arc cross-track error block
// no dependencies; imported by act_geometry, act_dist and arc_cross_track_error
package act_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int CORDIC_STEPS = 24;
   localparam int ROOT_BITS    = 34;
   localparam int SQ_W         = 68;

   localparam logic signed [33:0] CORDIC_START = 34'sd652032874;
   localparam logic signed [25:0] DEG_TO_RAD   = 26'sd18740330;
   localparam logic signed [26:0] H90          = 27'(90 << FRAC_BITS);
   localparam logic signed [26:0] H180         = 27'(180 << FRAC_BITS);

   // csr register indexes
   localparam logic [2:0] REG_FIRST_X        = 3'd0;
   localparam logic [2:0] REG_FIRST_Y        = 3'd1;
   localparam logic [2:0] REG_FIRST_HEADING  = 3'd2;
   localparam logic [2:0] REG_SECOND_X       = 3'd3;
   localparam logic [2:0] REG_SECOND_Y       = 3'd4;
   localparam logic [2:0] REG_SECOND_HEADING = 3'd5;

   // result status codes
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_DEGEN = 2'd1;
   localparam logic [1:0] STAT_SAT   = 2'd2;

   // arc geometry handed from the solver to the output stage
   typedef struct packed {
      logic              degen;
      logic              sat;
      logic signed [31:0] cx;
      logic signed [31:0] cy;
      logic [33:0]        r_full;
      logic [30:0]        radius;
   } geo_type;

   // atan(2^-i) in radians q30
   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      logic signed [33:0] v;
      case (i)
         5'd0:  v = 34'sd843314857;
         5'd1:  v = 34'sd497837829;
         5'd2:  v = 34'sd263043837;
         5'd3:  v = 34'sd133525159;
         5'd4:  v = 34'sd67021687;
         5'd5:  v = 34'sd33543516;
         5'd6:  v = 34'sd16775851;
         5'd7:  v = 34'sd8388437;
         5'd8:  v = 34'sd4194283;
         5'd9:  v = 34'sd2097149;
         5'd10: v = 34'sd1048576;
         5'd11: v = 34'sd524288;
         5'd12: v = 34'sd262144;
         5'd13: v = 34'sd131072;
         5'd14: v = 34'sd65536;
         5'd15: v = 34'sd32768;
         5'd16: v = 34'sd16384;
         5'd17: v = 34'sd8192;
         5'd18: v = 34'sd4096;
         5'd19: v = 34'sd2048;
         5'd20: v = 34'sd1024;
         5'd21: v = 34'sd512;
         5'd22: v = 34'sd256;
         5'd23: v = 34'sd128;
         5'd24: v = 34'sd64;
         5'd25: v = 34'sd32;
         5'd26: v = 34'sd16;
         5'd27: v = 34'sd8;
         5'd28: v = 34'sd4;
         5'd29: v = 34'sd2;
         5'd30: v = 34'sd1;
         default: v = 34'sd0;
      endcase
      return v;
   endfunction

   // true when a value does not fit 32-bit signed
   function automatic logic out32(input logic signed [42:0] v);
      return (v > 43'sd2147483647) || (v < -43'sd2147483648);
   endfunction

   // clamp to 32-bit signed
   function automatic logic signed [31:0] sat32(input logic signed [42:0] v);
      logic signed [31:0] r;
      if (v > 43'sd2147483647) begin
         r = 32'sh7FFFFFFF;
      end else if (v < -43'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

FILE: rtl/arc_cross_track_error.sv
// an accepted start passes the distance pipeline and then the result register before the rsp_valid strobe
// the distance pipeline takes one vehicle beat per cycle while busy is low
// busy is high after reset and after each csr write while the arc solver runs
// (two cordic runs, six serial multiplies, two serial divides)
// synchronous active-high reset zeroes the waypoints, solver flags and valid bits and starts a solver run
// depends on act_pkg, act_geometry, act_dist and assert_macros.svh
`include "assert_macros.svh"

module arc_cross_track_error import act_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_vehicle_x,
   input  logic signed [31:0] req_vehicle_y,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_centre_x,
   output logic signed [31:0] rsp_centre_y,
   output logic [30:0]        rsp_radius,
   output logic signed [31:0] rsp_track_error,
   output logic [1:0]         rsp_status,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);

   geo_type            geo;
   logic               inject, accept;
   logic signed [31:0] inj_x, inj_y, px, py;
   logic               pipe_valid, pipe_tag;
   logic [33:0]        pipe_dist;
   logic signed [34:0] err_full;
   logic               err_sat;
   logic               rsp_valid_ff;
   logic signed [31:0] cx_ff, cy_ff, err_ff;
   logic [30:0]        radius_ff;
   logic [1:0]         status_ff;

   act_geometry u_geometry (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .csr_ready (csr_ready),
      .busy      (busy),
      .inject    (inject),
      .inj_x     (inj_x),
      .inj_y     (inj_y),
      .rad_valid (pipe_valid & pipe_tag),
      .rad_dist  (pipe_dist),
      .geo       (geo)
   );

   // vehicle beats, or the second waypoint when the solver needs the radius
   assign accept = start & ~busy;
   assign px     = inject ? inj_x : req_vehicle_x;
   assign py     = inject ? inj_y : req_vehicle_y;

   act_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept | inject),
      .in_tag    (inject),
      .in_px     (px),
      .in_py     (py),
      .in_cx     (geo.cx),
      .in_cy     (geo.cy),
      .out_valid (pipe_valid),
      .out_tag   (pipe_tag),
      .out_dist  (pipe_dist)
   );

   // cross-track error from the unclamped radius
   assign err_full = signed'(35'(geo.r_full) - 35'(pipe_dist));
   assign err_sat  = out32(43'(err_full));

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= pipe_valid & ~pipe_tag;
      end
      if (geo.degen) begin
         cx_ff     <= '0;
         cy_ff     <= '0;
         radius_ff <= '0;
         err_ff    <= '0;
         status_ff <= STAT_DEGEN;
      end else begin
         cx_ff     <= geo.cx;
         cy_ff     <= geo.cy;
         radius_ff <= geo.radius;
         err_ff    <= sat32(43'(err_full));
         status_ff <= (geo.sat | err_sat) ? STAT_SAT : STAT_OK;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_centre_x    = cx_ff;
   assign rsp_centre_y    = cy_ff;
   assign rsp_radius      = radius_ff;
   assign rsp_track_error = err_ff;
   assign rsp_status      = status_ff;

   // csr port and start port open and close together
   `ACT_ASSERT_ALWAYS(a_ready_vs_busy, clock, reset, csr_ready == !busy)
   // degenerate results carry no geometry
   `ACT_ASSERT_IMP(a_degen_zero, clock, reset, rsp_valid && rsp_status == STAT_DEGEN, rsp_radius == 31'd0 && rsp_track_error == 32'sd0)

endmodule

FILE: rtl/act_geometry.sv
// waypoint registers and sequential arc solver: cordic, serial multiply, divide
// depends on act_pkg and assert_macros.svh
`include "assert_macros.svh"

module act_geometry import act_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output logic               csr_ready,
   output logic               busy,
   output logic               inject,
   output logic signed [31:0] inj_x,
   output logic signed [31:0] inj_y,
   input  logic               rad_valid,
   input  logic [33:0]        rad_dist,
   output geo_type            geo
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_REDUCE, ST_ROTATE, ST_STORE, ST_MLOAD, ST_MUL, ST_MEND,
      ST_DIV, ST_DEND, ST_INJECT, ST_WAIT
   } state_type;

   state_type          state_ff;
   logic signed [31:0] wp1_x_ff, wp1_y_ff, wp2_x_ff, wp2_y_ff;
   logic signed [24:0] wp1_h_ff, wp2_h_ff;
   logic               which_ff, degen_ff, sat_ff, neg_ff, divneg_ff;
   logic [4:0]         step_ff;
   logic [6:0]         cnt_ff;
   logic [2:0]         mop_ff;
   logic signed [33:0] x_ff, y_ff, z_ff;
   logic signed [31:0] c1_ff, s1_ff, c2_ff, s2_ff, cx_ff, cy_ff;
   logic signed [63:0] det_ff, num_ff;
   logic [95:0]        mul_a_ff, acc_ff, q_ff;
   logic [31:0]        mul_b_ff;
   logic [57:0]        dvs_ff, rem_ff;
   logic [33:0]        r_full_ff;
   logic [30:0]        radius_ff;

   logic signed [26:0] h_sel, h_r0, h_r1, h_r2;
   logic               red_degen;
   logic signed [52:0] z_prod;
   logic signed [33:0] z_in, x_sh, y_sh, atan_v;
   logic signed [63:0] op_a, prod64, det_next, det_abs;
   logic signed [31:0] op_b;
   logic [63:0]        mag_a;
   logic [31:0]        mag_b;
   logic [58:0]        rem_sh;
   logic               rem_ge;
   logic [57:0]        rem_nx;
   logic [40:0]        q_clip;
   logic signed [42:0] q_signed, cx_full, cy_full;

   // heading reduction into [-90, 90) degrees and conversion to radians
   always_comb begin
      h_sel = which_ff ? 27'(wp2_h_ff) : 27'(wp1_h_ff);
      if (h_sel >= H180) begin
         h_r0 = h_sel - H180;
      end else if (h_sel <= -H180) begin
         h_r0 = h_sel + H180;
      end else begin
         h_r0 = h_sel;
      end
      h_r1 = (h_r0 < 0) ? h_r0 + H180 : h_r0;
      h_r2 = (h_r1 >= H90) ? h_r1 - H180 : h_r1;
      red_degen = (h_r2 == 27'sd0) || (h_r2 == -H90);
      z_prod = h_r2 * DEG_TO_RAD;
      z_in = 34'(z_prod >>> FRAC_BITS);
   end

   // cordic micro-rotation terms
   assign x_sh   = x_ff >>> step_ff;
   assign y_sh   = y_ff >>> step_ff;
   assign atan_v = atan_q30(step_ff);

   // multiply operand select
   always_comb begin
      case (mop_ff)
         3'd0: begin op_a = 64'(c1_ff); op_b = s2_ff; end
         3'd1: begin op_a = 64'(s1_ff); op_b = c2_ff; end
         3'd2: begin op_a = 64'(wp2_x_ff) - 64'(wp1_x_ff); op_b = c2_ff; end
         3'd3: begin op_a = 64'(wp2_y_ff) - 64'(wp1_y_ff); op_b = s2_ff; end
         3'd4: begin op_a = num_ff; op_b = s1_ff; end
         3'd5: begin op_a = num_ff; op_b = c1_ff; end
         default: begin op_a = 64'sd0; op_b = 32'sd0; end
      endcase
      mag_a = op_a[63] ? 64'(-op_a) : 64'(op_a);
      mag_b = op_b[31] ? 32'(-op_b) : 32'(op_b);
   end

   // product sign fix and determinant update
   assign prod64   = neg_ff ? -signed'(acc_ff[63:0]) : signed'(acc_ff[63:0]);
   assign det_next = det_ff - prod64;
   assign det_abs  = det_ff[63] ? -det_ff : det_ff;

   // restoring divide step
   assign rem_sh = {rem_ff, acc_ff[95]};
   assign rem_ge = rem_sh >= {1'b0, dvs_ff};
   assign rem_nx = rem_ge ? 58'(rem_sh - {1'b0, dvs_ff}) : rem_sh[57:0];

   // quotient clamp and centre coordinate
   always_comb begin
      q_clip   = (q_ff > (96'd1 << 40)) ? (41'd1 << 40) : q_ff[40:0];
      q_signed = divneg_ff ? -signed'({2'b00, q_clip}) : signed'({2'b00, q_clip});
      cx_full  = 43'(wp1_x_ff) - q_signed;
      cy_full  = 43'(wp1_y_ff) + q_signed;
   end

   // solver sequencer and waypoint registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_REDUCE;
         wp1_x_ff <= '0;
         wp1_y_ff <= '0;
         wp1_h_ff <= '0;
         wp2_x_ff <= '0;
         wp2_y_ff <= '0;
         wp2_h_ff <= '0;
         which_ff <= 1'b0;
         degen_ff <= 1'b0;
         sat_ff   <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (csr_valid) begin
                  case (csr_index)
                     REG_FIRST_X:        wp1_x_ff <= csr_data;
                     REG_FIRST_Y:        wp1_y_ff <= csr_data;
                     REG_FIRST_HEADING:  wp1_h_ff <= csr_data[24:0];
                     REG_SECOND_X:       wp2_x_ff <= csr_data;
                     REG_SECOND_Y:       wp2_y_ff <= csr_data;
                     REG_SECOND_HEADING: wp2_h_ff <= csr_data[24:0];
                     default: ;
                  endcase
                  which_ff <= 1'b0;
                  degen_ff <= 1'b0;
                  sat_ff   <= 1'b0;
                  state_ff <= ST_REDUCE;
               end
            end
            ST_REDUCE: begin
               degen_ff <= degen_ff | red_degen;
               z_ff     <= z_in;
               x_ff     <= CORDIC_START;
               y_ff     <= '0;
               step_ff  <= '0;
               state_ff <= ST_ROTATE;
            end
            ST_ROTATE: begin
               if (z_ff >= 0) begin
                  x_ff <= x_ff - y_sh;
                  y_ff <= y_ff + x_sh;
                  z_ff <= z_ff - atan_v;
               end else begin
                  x_ff <= x_ff + y_sh;
                  y_ff <= y_ff - x_sh;
                  z_ff <= z_ff + atan_v;
               end
               step_ff <= step_ff + 5'd1;
               if (step_ff == 5'(CORDIC_STEPS - 1)) begin
                  state_ff <= ST_STORE;
               end
            end
            ST_STORE: begin
               if (!which_ff) begin
                  c1_ff    <= 32'(x_ff >>> 2);
                  s1_ff    <= 32'(y_ff >>> 2);
                  which_ff <= 1'b1;
                  state_ff <= ST_REDUCE;
               end else begin
                  c2_ff    <= 32'(x_ff >>> 2);
                  s2_ff    <= 32'(y_ff >>> 2);
                  mop_ff   <= 3'd0;
                  state_ff <= degen_ff ? ST_IDLE : ST_MLOAD;
               end
            end
            ST_MLOAD: begin
               mul_a_ff <= 96'(mag_a);
               mul_b_ff <= mag_b;
               neg_ff   <= op_a[63] ^ op_b[31];
               acc_ff   <= '0;
               cnt_ff   <= '0;
               state_ff <= ST_MUL;
            end
            ST_MUL: begin
               if (mul_b_ff[0]) begin
                  acc_ff <= acc_ff + mul_a_ff;
               end
               mul_a_ff <= mul_a_ff << 1;
               mul_b_ff <= mul_b_ff >> 1;
               cnt_ff   <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd31) begin
                  state_ff <= ST_MEND;
               end
            end
            ST_MEND: begin
               case (mop_ff)
                  3'd0: begin
                     det_ff   <= prod64;
                     mop_ff   <= 3'd1;
                     state_ff <= ST_MLOAD;
                  end
                  3'd1: begin
                     det_ff <= det_next;
                     mop_ff <= 3'd2;
                     if (det_next == 64'sd0) begin
                        degen_ff <= 1'b1;
                        state_ff <= ST_IDLE;
                     end else begin
                        state_ff <= ST_MLOAD;
                     end
                  end
                  3'd2: begin
                     num_ff   <= prod64;
                     mop_ff   <= 3'd3;
                     state_ff <= ST_MLOAD;
                  end
                  3'd3: begin
                     num_ff   <= num_ff + prod64;
                     mop_ff   <= 3'd4;
                     state_ff <= ST_MLOAD;
                  end
                  default: begin
                     dvs_ff    <= det_abs[57:0];
                     divneg_ff <= neg_ff ^ det_ff[63];
                     rem_ff    <= '0;
                     q_ff      <= '0;
                     cnt_ff    <= '0;
                     state_ff  <= ST_DIV;
                  end
               endcase
            end
            ST_DIV: begin
               rem_ff <= rem_nx;
               q_ff   <= {q_ff[94:0], rem_ge};
               acc_ff <= acc_ff << 1;
               cnt_ff <= cnt_ff + 7'd1;
               if (cnt_ff == 7'd95) begin
                  state_ff <= ST_DEND;
               end
            end
            ST_DEND: begin
               if (mop_ff == 3'd4) begin
                  cx_ff    <= sat32(cx_full);
                  sat_ff   <= sat_ff | out32(cx_full);
                  mop_ff   <= 3'd5;
                  state_ff <= ST_MLOAD;
               end else begin
                  cy_ff    <= sat32(cy_full);
                  sat_ff   <= sat_ff | out32(cy_full);
                  state_ff <= ST_INJECT;
               end
            end
            ST_INJECT: begin
               state_ff <= ST_WAIT;
            end
            ST_WAIT: begin
               if (rad_valid) begin
                  r_full_ff <= rad_dist;
                  if (rad_dist > 34'h07FFFFFFF) begin
                     radius_ff <= 31'h7FFFFFFF;
                     sat_ff    <= 1'b1;
                  end else begin
                     radius_ff <= rad_dist[30:0];
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   // handshake and geometry outputs
   assign csr_ready = (state_ff == ST_IDLE);
   assign busy      = (state_ff != ST_IDLE);
   assign inject    = (state_ff == ST_INJECT);
   assign inj_x     = wp2_x_ff;
   assign inj_y     = wp2_y_ff;

   always_comb begin
      geo.degen  = degen_ff;
      geo.sat    = sat_ff;
      geo.cx     = cx_ff;
      geo.cy     = cy_ff;
      geo.r_full = r_full_ff;
      geo.radius = radius_ff;
   end

   // radius beat only returns while the solver waits for it
   `ACT_ASSERT_IMP(a_rad_when_waiting, clock, reset, rad_valid, state_ff == ST_WAIT)

endmodule

FILE: rtl/act_dist.sv
// pipelined distance unit: difference, squares, sum, then one root bit per stage
// depends on act_pkg and assert_macros.svh
`include "assert_macros.svh"

module act_dist import act_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_tag,
   input  logic signed [31:0] in_px,
   input  logic signed [31:0] in_py,
   input  logic signed [31:0] in_cx,
   input  logic signed [31:0] in_cy,
   output logic               out_valid,
   output logic               out_tag,
   output logic [33:0]        out_dist
);

   localparam int LAT = 3 + ROOT_BITS;

   logic signed [32:0] dx, dy;
   logic [32:0]        ax_ff, ay_ff;
   logic [65:0]        sx_ff, sy_ff;
   logic               v1_ff, v2_ff, t1_ff, t2_ff;
   logic [SQ_W-1:0]    op_ff  [0:ROOT_BITS];
   logic [SQ_W-1:0]    res_ff [0:ROOT_BITS];
   logic               vld_ff [0:ROOT_BITS];
   logic               tag_ff [0:ROOT_BITS];

   // coordinate differences
   assign dx = 33'(in_px) - 33'(in_cx);
   assign dy = 33'(in_py) - 33'(in_cy);

   // stage 1 magnitudes, stage 2 squares, stage 3 sum
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         vld_ff[0] <= 1'b0;
      end else begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         vld_ff[0] <= v2_ff;
      end
      t1_ff     <= in_tag;
      ax_ff     <= dx[32] ? 33'(-dx) : 33'(dx);
      ay_ff     <= dy[32] ? 33'(-dy) : 33'(dy);
      t2_ff     <= t1_ff;
      sx_ff     <= ax_ff * ax_ff;
      sy_ff     <= ay_ff * ay_ff;
      tag_ff[0] <= t2_ff;
      op_ff[0]  <= SQ_W'(sx_ff) + SQ_W'(sy_ff);
      res_ff[0] <= '0;
   end

   // digit-by-digit square root, one result bit per stage
   for (genvar k = 0; k < ROOT_BITS; k++) begin : g_root
      localparam logic [SQ_W-1:0] ONE = SQ_W'(1) << (2 * (ROOT_BITS - 1 - k));
      logic [SQ_W-1:0] trial;
      logic            take;

      assign trial = res_ff[k] + ONE;
      assign take  = op_ff[k] >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else begin
            vld_ff[k+1] <= vld_ff[k];
         end
         tag_ff[k+1] <= tag_ff[k];
         if (take) begin
            op_ff[k+1]  <= op_ff[k] - trial;
            res_ff[k+1] <= (res_ff[k] >> 1) + ONE;
         end else begin
            op_ff[k+1]  <= op_ff[k];
            res_ff[k+1] <= res_ff[k] >> 1;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_BITS];
   assign out_tag   = tag_ff[ROOT_BITS];
   assign out_dist  = res_ff[ROOT_BITS][33:0];

   // valid and tag travel unchanged through the whole pipe
   `ACT_ASSERT_IMP(a_valid_latency, clock, reset, out_valid, $past(in_valid, LAT))
   `ACT_ASSERT_IMP(a_tag_latency, clock, reset, out_valid, out_tag == $past(in_tag, LAT))

endmodule
